// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg: shared types and codes of the integer text parser
// Holds the word types of both channels, the parse state record and the
// phase, radix, status and register index codes.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Parse phases.
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SIGNED = 2'd1;
	localparam logic [1:0] PH_ZERO   = 2'd2;
	localparam logic [1:0] PH_DIGITS = 2'd3;

	// Radix codes.
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_BIN = 2'd1;
	localparam logic [1:0] RX_OCT = 2'd2;
	localparam logic [1:0] RX_HEX = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCHAR = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_MINUS   = 2'd3;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_SEL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED    = 2'd1;
	localparam logic [1:0] WIDTH_SEL_RESET = 2'd3;
	localparam logic       SIGNED_RESET    = 1'b1;

	// Input word: one character.
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_word_t;

	// Output word: one parse result.
	typedef struct packed {
		logic [63:0] value_bits;
		logic [1:0]  status;
	} out_word_t;

	// State carried from one character to the next.
	typedef struct packed {
		logic [1:0]  phase;
		logic        neg;
		logic [1:0]  radix;
		logic [63:0] acc;
		logic        ovf;
		logic [1:0]  err;
	} parse_state_t;

	// Finished string handed to the range check.
	typedef struct packed {
		logic [63:0] acc;
		logic        neg;
		logic        ovf;
		logic [1:0]  err;
		logic [1:0]  width_sel;
		logic        signed_mode;
	} final_req_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_START, neg: 1'b0, radix: RX_DEC, acc: 64'd0, ovf: 1'b0, err: ST_OK
	};

endpackage

// ===== src/itp_step.sv =====
// ----------------------------------------------------------------------------
// itp_step: per-character parse step
// Folds one character into the parse state: sign, radix prefix detection,
// digit check and shift-add accumulation with carry-out detection.
// ----------------------------------------------------------------------------
module itp_step import itp_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   char_code,
	input  logic         last_char,
	input  logic         signed_mode,
	output parse_state_t nxt
);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	logic [1:0]  rx_use;
	logic [4:0]  digit;
	logic        digit_bad;
	logic        use_digit;
	logic [67:0] acc_w;
	logic [67:0] scaled;
	logic [67:0] sum;

	// The radix a digit is checked against: decimal for a first digit; after
	// a leading zero, octal for 0-7 and else decimal; else the latched radix.
	always_comb begin
		case (cur.phase)
			PH_START, PH_SIGNED: rx_use = RX_DEC;
			PH_ZERO: rx_use = (char_code >= CH_0 && char_code <= CH_7) ? RX_OCT : RX_DEC;
			default: rx_use = cur.radix;
		endcase
	end

	// Digit value; 16 marks a character that is not 0-9 or, in hex, a-f or A-F.
	always_comb begin
		digit = 5'd16;
		if (char_code >= CH_0 && char_code <= CH_9) begin
			digit = 5'(char_code - CH_0);
		end else if (rx_use == RX_HEX && char_code >= CH_LA && char_code <= CH_LF) begin
			digit = 5'(char_code - CH_LA + 8'd10);
		end else if (rx_use == RX_HEX && char_code >= CH_UA && char_code <= CH_UF) begin
			digit = 5'(char_code - CH_UA + 8'd10);
		end
		case (rx_use)
			RX_BIN:  digit_bad = (digit >= 5'd2);
			RX_OCT:  digit_bad = (digit >= 5'd8);
			RX_HEX:  digit_bad = (digit >= 5'd16);
			default: digit_bad = (digit >= 5'd10);
		endcase
	end

	// Shift-add accumulate over 68 bits; any carry past bit 63 is overflow.
	always_comb begin
		acc_w = {4'd0, cur.acc};
		case (rx_use)
			RX_BIN:  scaled = acc_w << 1;
			RX_OCT:  scaled = acc_w << 3;
			RX_HEX:  scaled = acc_w << 4;
			default: scaled = (acc_w << 3) + (acc_w << 1);
		endcase
		sum = scaled + {64'd0, digit[3:0]};
	end

	// Phase sequencing; a latched error freezes the state until the end.
	always_comb begin
		nxt = cur;
		use_digit = 1'b0;
		if (cur.err == ST_OK) begin
			case (cur.phase)
				PH_START: begin
					if (char_code == CH_PLUS) begin
						nxt.phase = PH_SIGNED;
					end else if (char_code == CH_MINUS) begin
						nxt.neg = 1'b1;
						nxt.phase = PH_SIGNED;
						if (!signed_mode) begin
							nxt.err = ST_MINUS;
						end
					end else if (char_code == CH_0 && !last_char) begin
						nxt.phase = PH_ZERO;
					end else begin
						nxt.radix = RX_DEC;
						nxt.phase = PH_DIGITS;
						use_digit = 1'b1;
					end
				end
				PH_SIGNED: begin
					if (char_code == CH_0 && !last_char) begin
						nxt.phase = PH_ZERO;
					end else begin
						nxt.radix = RX_DEC;
						nxt.phase = PH_DIGITS;
						use_digit = 1'b1;
					end
				end
				PH_ZERO: begin
					nxt.phase = PH_DIGITS;
					if (char_code == CH_LB || char_code == CH_UB) begin
						nxt.radix = RX_BIN;
					end else if (char_code == CH_LX || char_code == CH_UX) begin
						nxt.radix = RX_HEX;
					end else begin
						nxt.radix = rx_use;
						use_digit = 1'b1;
					end
				end
				default: begin
					use_digit = 1'b1;
				end
			endcase
		end
		if (use_digit) begin
			if (digit_bad) begin
				nxt.err = ST_BADCHAR;
			end else begin
				nxt.acc = sum[63:0];
				if (sum[67:64] != 4'd0) begin
					nxt.ovf = 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/itp_final.sv =====
// ----------------------------------------------------------------------------
// itp_final: range check and sign application
// Turns a finished string into its result word: the latched error first,
// then accumulator overflow, then the range of the configured width.
// ----------------------------------------------------------------------------
module itp_final import itp_pkg::*; (
	input  final_req_t req,
	output out_word_t  res
);

	logic [63:0] umax;
	logic [63:0] limit;
	logic [63:0] neg_acc;

	// Largest unsigned value of the target width.
	always_comb begin
		case (req.width_sel)
			2'd0:    umax = 64'h0000_0000_0000_00FF;
			2'd1:    umax = 64'h0000_0000_0000_FFFF;
			2'd2:    umax = 64'h0000_0000_FFFF_FFFF;
			default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	end

	// Magnitude limit for the sign and mode at hand.
	always_comb begin
		if (!req.signed_mode) begin
			limit = umax;
		end else if (req.neg) begin
			limit = (umax >> 1) + 64'd1;
		end else begin
			limit = umax >> 1;
		end
		neg_acc = 64'd0 - req.acc;
	end

	// Status priority and the value that goes with it.
	always_comb begin
		res.value_bits = 64'd0;
		res.status = req.err;
		if (req.err == ST_OK) begin
			if (req.ovf || req.acc > limit) begin
				res.status = ST_RANGE;
			end else if (req.signed_mode && req.neg) begin
				res.value_bits = neg_acc;
			end else begin
				res.value_bits = req.acc;
			end
		end
	end

endmodule

// ===== src/integer_text_parser.sv =====
// ----------------------------------------------------------------------------
// integer_text_parser: text string to integer with radix prefix
// Reads one character word per cycle while char_stall is low and gives one
// result word for each string, on the character marked last.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Word
//  char     char_valid/char_stall  char_word (char_code, last_char)
//  result   result_valid/stall     result_word (value_bits, status)
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One character word is accepted every cycle while char_stall is low; the
// per-character step is a single shift-add and digit check between the
// input register and the state. A result word passes the input register,
// the range-check register and the output register, in that order.
// Reset clears all control state and the configuration to 64-bit signed.
// A stall on the result channel fills the range-check and output registers
// before it backs up to char_stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module integer_text_parser import itp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  in_word_t               char_word,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_word_t              result_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic         width_sel_hit;
	logic [1:0]   width_q;
	logic         signed_q;
	logic         valid_s1;
	in_word_t     char_s1;
	parse_state_t st_q;
	parse_state_t st_next;
	logic         valid_s2;
	final_req_t   req_s2;
	logic         valid_s3;
	out_word_t    res_s3;
	out_word_t    fin_res;
	logic         out_free;
	logic         fin_go;
	logic         s2_free;
	logic         s1_go;
	logic         s1_free;

	assign width_sel_hit = (cfg_index == CFG_WIDTH_SEL);

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_SEL_RESET;
			signed_q <= SIGNED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (width_sel_hit) begin
				width_q <= cfg_data[1:0];
			end else if (cfg_index == CFG_SIGNED) begin
				signed_q <= cfg_data[0];
			end
		end
	end

	// Flow control: a register moves when the next is free, save a non-last char.
	assign out_free = !valid_s3 || !result_stall;
	assign fin_go = valid_s2 && out_free;
	assign s2_free = !valid_s2 || out_free;
	assign s1_go = valid_s1 && (!char_s1.last_char || s2_free);
	assign s1_free = !valid_s1 || s1_go;
	assign char_stall = !s1_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && s1_free) begin
			char_s1 <= char_word;
		end
	end

	itp_step u_step (
		.cur         (st_q),
		.char_code   (char_s1.char_code),
		.last_char   (char_s1.last_char),
		.signed_mode (signed_q),
		.nxt         (st_next)
	);

	// Parse state; it returns to its reset value after the last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (s1_go) begin
			st_q <= char_s1.last_char ? STATE_RESET : st_next;
		end
	end

	// Finished-string register, with the configuration seen at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && char_s1.last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && char_s1.last_char) begin
			req_s2.acc <= st_next.acc;
			req_s2.neg <= st_next.neg;
			req_s2.ovf <= st_next.ovf;
			req_s2.err <= st_next.err;
			req_s2.width_sel <= width_q;
			req_s2.signed_mode <= signed_q;
		end
	end

	itp_final u_final (
		.req (req_s2),
		.res (fin_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			res_s3 <= fin_res;
		end
	end

	assign result_valid = valid_s3;
	assign result_word = res_s3;

`ifndef ASSERT_OFF
	// A failed parse never carries a value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status != ST_OK |-> result_word.value_bits == 64'd0)
		else $error("failed result carries a nonzero value");

	// The input side only stalls while it holds a word.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1)
		else $error("char_stall with an empty input register");

	// The last character leaves the parse state cleared.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && char_s1.last_char |=> st_q.phase == PH_START && st_q.acc == 64'd0)
		else $error("parse state not cleared after last character");

	// A latched error never sits in the leading-zero phase.
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err != ST_OK |-> st_q.phase != PH_ZERO)
		else $error("error latched in leading-zero phase");

	// Nothing has accumulated while waiting on a possible radix prefix.
	a_zero_acc: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_ZERO |-> st_q.acc == 64'd0)
		else $error("accumulator nonzero after leading zero");
`endif

endmodule
